[src/mrct_pkg.sv]
// Shared constants, types and helper functions for the moving-window RMS core.
// Used by the top level and the ring RAM; has no dependencies of its own.
package mrct_pkg;

    // Default ring depth.
    localparam int WINDOW_DEF = 16;

    // Field widths.
    localparam int RAW_W      = 10;
    localparam int SQ_W       = 2 * RAW_W;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int RMS_W      = 16;
    localparam int MA_W       = 16;
    localparam int TQ_W       = 24;

    // The mean square is scaled by 4096 so that its root has six fraction bits.
    localparam int FRAC_SHIFT = 12;

    // Current scaling: rms * 5000000 / (65472 * mv_per_amp).
    localparam int SCALE_W = 23;
    localparam int DEN_W   = 32;
    localparam logic [SCALE_W-1:0] CUR_SCALE  = 23'd5000000;
    localparam logic [CFG_W-1:0]   FULL_CODE  = 16'd65472;
    localparam logic [9:0]         TQ_DIVISOR = 10'd1000;

    // Register reset values.
    localparam logic [CFG_W-1:0] MV_PER_AMP_RST = 16'd1000;
    localparam logic [CFG_W-1:0] TORQUE_K_RST   = 16'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MV_PER_AMP = 4'd0,
        CFG_TORQUE_K   = 4'd1
    } t_cfg_idx;

    // Address width for a given depth, at least one bit.
    function automatic int clog2_min1(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

[src/moving_rms_current_torque_core.sv]
// Requests are taken one at a time: the request channel stalls from acceptance until
// the result is moved to the output register, and the three passes of the bit-serial
// divider take most of that time. A finished result waits in the output register
// while the next request is taken.
// Reset (synchronous, active low) clears position, fill count, sum and output
// valid and loads the register defaults; unwritten ring entries count as zero.
module moving_rms_current_torque_core import mrct_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Sample request channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [RAW_W-1:0]     i_adc_sample,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [RMS_W-1:0]     o_rms_code,
    output logic [MA_W-1:0]      o_current_ma,
    output logic [TQ_W-1:0]      o_torque_out,
    // Register write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int POS_W  = clog2_min1(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SQ_W + $clog2(WINDOW);
    localparam int MEAN_W = SUM_W + FRAC_SHIFT;
    localparam int RAD_W  = MEAN_W + (MEAN_W % 2);
    localparam int RT_W   = RAD_W / 2;
    localparam int PROD_W = RMS_W + SCALE_W;
    localparam int DV_W   = (RAD_W > PROD_W) ? RAD_W : PROD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_MEAN,
        S_MEAN_W,
        S_ROOT,
        S_ROOT_W,
        S_MUL,
        S_MA,
        S_MA_W,
        S_MUL_TQ,
        S_TQ,
        S_TQ_W,
        S_OUT
    } t_state;

    t_state            r_state,      n_state;
    logic [POS_W-1:0]  r_pos,        n_pos;
    logic [CNT_W-1:0]  r_cnt,        n_cnt;
    logic [SUM_W-1:0]  r_sum,        n_sum;
    logic [SQ_W-1:0]   r_square,     n_square;
    logic [RMS_W-1:0]  r_rms,        n_rms;
    logic [MA_W-1:0]   r_ma,         n_ma;
    logic [TQ_W-1:0]   r_tq,         n_tq;
    logic [PROD_W-1:0] r_prod,       n_prod;
    logic [DEN_W-1:0]  r_den,        n_den;
    logic [CFG_W-1:0]  r_mv_per_amp, n_mv_per_amp;
    logic [CFG_W-1:0]  r_torque_k,   n_torque_k;
    logic              r_out_valid,  n_out_valid;
    logic [RMS_W-1:0]  r_out_rms,    n_out_rms;
    logic [MA_W-1:0]   r_out_ma,     n_out_ma;
    logic [TQ_W-1:0]   r_out_tq,     n_out_tq;

    logic              ring_we;
    logic [SQ_W-1:0]   ring_rd;
    logic [SQ_W-1:0]   oldest;

    logic              div_start;
    logic [DV_W-1:0]   div_dividend;
    logic [DEN_W-1:0]  div_divisor;
    logic              div_done;
    logic [DV_W-1:0]   div_q;

    logic              sqrt_start;
    logic              sqrt_done;
    logic [RT_W-1:0]   sqrt_root;

    // Ring of squares; the entry at the current position is read on acceptance.
    mrct_ram #(
        .WIDTH (SQ_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_pos),
        .i_wdata (r_square),
        .i_raddr (r_pos),
        .o_rdata (ring_rd)
    );

    // Shared divider: mean square, then current, then torque.
    mrct_div #(
        .DV_W (DV_W),
        .DS_W (DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    mrct_sqrt #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (div_q[RAD_W-1:0]),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // Operand selection for the divider.
    always_comb begin
        div_start = (r_state == S_MEAN) || (r_state == S_MA) || (r_state == S_TQ);
        if (r_state == S_MEAN) begin
            div_dividend = DV_W'({r_sum, {FRAC_SHIFT{1'b0}}});
            div_divisor  = DEN_W'(r_cnt);
        end else if (r_state == S_MA) begin
            div_dividend = DV_W'(r_prod);
            div_divisor  = r_den;
        end else begin
            div_dividend = DV_W'(r_prod);
            div_divisor  = DEN_W'(TQ_DIVISOR);
        end
    end

    assign sqrt_start = (r_state == S_ROOT);
    assign ring_we    = (r_state == S_SUM);

    // Until the ring has filled once, the entry being replaced was never written.
    assign oldest = (r_cnt == CNT_W'(WINDOW)) ? ring_rd : '0;

    // Next-state logic for the sequencer, datapath and output register.
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_sum        = r_sum;
        n_square     = r_square;
        n_rms        = r_rms;
        n_ma         = r_ma;
        n_tq         = r_tq;
        n_prod       = r_prod;
        n_den        = r_den;
        n_mv_per_amp = r_mv_per_amp;
        n_torque_k   = r_torque_k;
        n_out_valid  = r_out_valid;
        n_out_rms    = r_out_rms;
        n_out_ma     = r_out_ma;
        n_out_tq     = r_out_tq;

        // Register writes.
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MV_PER_AMP: n_mv_per_amp = i_cfg_data;
                CFG_TORQUE_K:   n_torque_k   = i_cfg_data;
                default: ;
            endcase
        end

        // A taken result frees the output register.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_square = SQ_W'(i_adc_sample) * SQ_W'(i_adc_sample);
                    n_state  = S_SUM;
                end
            end
            S_SUM: begin
                n_sum = r_sum - SUM_W'(oldest) + SUM_W'(r_square);
                n_pos = (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
                if (r_cnt != CNT_W'(WINDOW)) begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_state = S_MEAN;
            end
            S_MEAN: n_state = S_MEAN_W;
            S_MEAN_W: begin
                if (div_done) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: n_state = S_ROOT_W;
            S_ROOT_W: begin
                if (sqrt_done) begin
                    n_rms   = (sqrt_root > RT_W'({RMS_W{1'b1}})) ? '1 : sqrt_root[RMS_W-1:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_rms) * PROD_W'(CUR_SCALE);
                n_den   = DEN_W'(r_mv_per_amp) * DEN_W'(FULL_CODE);
                n_state = S_MA;
            end
            S_MA: n_state = S_MA_W;
            S_MA_W: begin
                if (div_done) begin
                    n_ma    = (div_q > DV_W'({MA_W{1'b1}})) ? '1 : div_q[MA_W-1:0];
                    n_state = S_MUL_TQ;
                end
            end
            S_MUL_TQ: begin
                n_prod  = PROD_W'(r_torque_k) * PROD_W'(r_ma);
                n_state = S_TQ;
            end
            S_TQ: n_state = S_TQ_W;
            S_TQ_W: begin
                if (div_done) begin
                    n_tq    = (div_q > DV_W'({TQ_W{1'b1}})) ? '1 : div_q[TQ_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_rms   = r_rms;
                    n_out_ma    = r_ma;
                    n_out_tq    = r_tq;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, datapath and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= '0;
            r_cnt        <= '0;
            r_sum        <= '0;
            r_mv_per_amp <= MV_PER_AMP_RST;
            r_torque_k   <= TORQUE_K_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_cnt        <= n_cnt;
            r_sum        <= n_sum;
            r_square     <= n_square;
            r_rms        <= n_rms;
            r_ma         <= n_ma;
            r_tq         <= n_tq;
            r_prod       <= n_prod;
            r_den        <= n_den;
            r_mv_per_amp <= n_mv_per_amp;
            r_torque_k   <= n_torque_k;
            r_out_valid  <= n_out_valid;
            r_out_rms    <= n_out_rms;
            r_out_ma     <= n_out_ma;
            r_out_tq     <= n_out_tq;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_rms_code   = r_out_rms;
    assign o_current_ma = r_out_ma;
    assign o_torque_out = r_out_tq;

endmodule

[src/mrct_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on mrct_pkg for the address width helper and the parameter defaults.
module mrct_ram import mrct_pkg::*; #(
    parameter int WIDTH = SQ_W,
    parameter int DEPTH = WINDOW_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [clog2_min1(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic [clog2_min1(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/mrct_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Standalone; a zero divisor gives an all-ones quotient.
module mrct_div #(
    parameter int DV_W = 39,
    parameter int DS_W = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DV_W-1:0] i_dividend,
    input  logic [DS_W-1:0] i_divisor,
    output logic            o_done,
    output logic [DV_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DV_W + 1);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } t_dstate;

    t_dstate          r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [DV_W-1:0]  r_dvd;
    logic [DS_W-1:0]  r_dvs;
    logic [DS_W:0]    r_rem;
    logic             r_done;

    logic [DS_W:0]    rem_sh;
    logic             fits;

    // One step: shift in the next dividend bit and try to subtract.
    always_comb begin
        rem_sh = {r_rem[DS_W-1:0], r_dvd[DV_W-1]};
        fits   = (rem_sh >= {1'b0, r_dvs});
    end

    // The dividend register fills with quotient bits from the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_dvd   <= i_dividend;
                        r_dvs   <= i_divisor;
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(DV_W);
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= fits ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
                    r_dvd <= {r_dvd[DV_W-2:0], fits};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

[src/mrct_sqrt.sv]
// Digit-serial integer square root: two radicand bits and one root bit per cycle.
// Standalone; the radicand width must be even.
module mrct_sqrt #(
    parameter int RAD_W = 36
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [RAD_W-1:0]   i_radicand,
    output logic               o_done,
    output logic [RAD_W/2-1:0] o_root
);

    localparam int RT_W  = RAD_W / 2;
    localparam int CNT_W = $clog2(RT_W + 1);

    typedef enum logic {
        Q_IDLE,
        Q_RUN
    } t_qstate;

    t_qstate          r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [RAD_W-1:0] r_rad;
    logic [RT_W-1:0]  r_root;
    logic [RT_W+1:0]  r_rem;
    logic             r_done;

    logic [RT_W+1:0]  rem_sh;
    logic [RT_W+1:0]  trial;
    logic             fits;

    // Bring down the next bit pair and test root*4+1 against the remainder.
    always_comb begin
        rem_sh = {r_rem[RT_W-1:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                Q_IDLE: begin
                    if (i_start) begin
                        r_rad   <= i_radicand;
                        r_root  <= '0;
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(RT_W);
                        r_state <= Q_RUN;
                    end
                end
                Q_RUN: begin
                    r_rem  <= fits ? (rem_sh - trial) : rem_sh;
                    r_root <= {r_root[RT_W-2:0], fits};
                    r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= Q_IDLE;
                    end
                end
                default: r_state <= Q_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[src/mrct_chk.sv]
// Port-level checker for the moving-window RMS core, bound to its top level.
// Depends on moving_rms_current_torque_core for the bind target.
module mrct_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_rms_code,
    input logic [15:0] o_current_ma,
    input logic [23:0] o_torque_out
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An accepted request keeps the block busy on the next cycle.
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after accepting a request");

    // A new result only comes out of a computation in progress.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in flight");

    // A stalled result stays and holds its payload.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_rms_code) && $stable(o_current_ma)
             && $stable(o_torque_out)))
        else $error("stalled result changed");

    // RMS of 10-bit codes cannot exceed full scale, and torque is bounded by the
    // largest register value times the saturated current.
    a_value_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_rms_code <= 16'd65472) && (o_torque_out <= 24'd4294836)))
        else $error("result out of range");

endmodule

bind moving_rms_current_torque_core mrct_chk u_mrct_chk (.*);
